@@ sv/uer_pkg.sv @@
// package for the ultrasonic echo ranger: phase codes, register map,
// reset values and the centimetre divisor; no dependencies
`timescale 1ns / 1ps

package uer_pkg;

   localparam int unsigned COUNTER_WIDTH_DEF = 16;
   localparam int unsigned CM_DIVISOR        = 58;
   localparam int unsigned REM_WIDTH         = $clog2(CM_DIVISOR);

   localparam int unsigned DIST_WIDTH    = 11;
   localparam int unsigned TRIG_WIDTH    = 8;
   localparam int unsigned TIMEOUT_WIDTH = 16;
   localparam int unsigned ADDR_WIDTH    = 4;
   localparam int unsigned DATA_WIDTH    = 32;

   localparam logic [DIST_WIDTH-1:0]    MAX_DIST_RST = DIST_WIDTH'(400);
   localparam logic [TRIG_WIDTH-1:0]    TRIG_RST     = TRIG_WIDTH'(12);
   localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RST  = TIMEOUT_WIDTH'(30000);

   typedef enum logic [1:0] {
      REG_MAX_DIST = 2'd0,
      REG_TRIG     = 2'd1,
      REG_TIMEOUT  = 2'd2,
      REG_NONE     = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_TRIG = 2'd1,
      PH_RISE = 2'd2,
      PH_FALL = 2'd3
   } phase_type;

endpackage

@@ sv/uer_req_if.sv @@
// input channel of the echo ranger: one word per microsecond tick
// depends on nothing
`timescale 1ns / 1ps

interface uer_req_if;
   logic valid;
   logic ready;
   logic start_req;
   logic echo;

   modport source (output valid, output start_req, output echo, input ready);
   modport sink   (input valid, input start_req, input echo, output ready);
endinterface

@@ sv/uer_rsp_if.sv @@
// result channel of the echo ranger: one word per accepted tick
// depends on uer_pkg for field widths
`timescale 1ns / 1ps

interface uer_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           trigger;
   logic                           busy_res;
   logic                           done_res;
   logic                           timed_out;
   logic [uer_pkg::DIST_WIDTH-1:0] distance_cm;

   modport source (output valid, output trigger, output busy_res, output done_res,
                   output timed_out, output distance_cm, input ready);
   modport sink   (input valid, input trigger, input busy_res, input done_res,
                   input timed_out, input distance_cm, output ready);
endinterface

@@ sv/ultrasonic_echo_ranger_unit.sv @@
// top level of the ultrasonic echo ranger: trigger sequencer, tick counter,
// running centimetre count and apb register file
// depends on uer_pkg, uer_req_if and uer_rsp_if
//
//   channel   kind        signals                                    word
//   req       valid/ready start_req, echo                            one tick
//   rsp       valid/ready trigger, busy_res, done_res, timed_out,    one per tick
//                         distance_cm
//   csr       apb         psel, penable, pwrite, paddr, pwdata,      32-bit regs
//                         prdata, pready
//
// one tick per cycle unless stalled; its result is in the output reg the next cycle
// the tick logic is one pass from the accepted word and the state into that register
// centimetres are counted during the echo (a mod-58 prescaler), so no divider is used
// req ready is low only while a result is held and rsp ready is low
// reset is synchronous and active high; registers return to 400, 12 and 30000 cm/ticks
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_unit #(
   parameter int unsigned COUNTER_WIDTH = uer_pkg::COUNTER_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   uer_req_if.sink                        req,
   uer_rsp_if.source                      rsp,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [uer_pkg::ADDR_WIDTH-1:0] paddr,
   input  logic [uer_pkg::DATA_WIDTH-1:0] pwdata,
   output logic [uer_pkg::DATA_WIDTH-1:0] prdata,
   output logic                           pready
);
   import uer_pkg::*;

   logic [DIST_WIDTH-1:0]    max_dist_ff;
   logic [TRIG_WIDTH-1:0]    trig_len_ff;
   logic [TIMEOUT_WIDTH-1:0] timeout_ff;
   reg_index_type            reg_sel;
   logic                     csr_write;

   phase_type                phase_ff, phase_in;
   logic [TRIG_WIDTH-1:0]    trig_cnt_ff, trig_cnt_in;
   logic [COUNTER_WIDTH-1:0] tick_cnt_ff, tick_cnt_in;
   logic [REM_WIDTH-1:0]     rem_ff, rem_in;
   logic [DIST_WIDTH-1:0]    cm_ff, cm_in;
   logic                     echo_prev_ff;

   logic                     rsp_valid_ff;
   logic                     rsp_trig_ff, rsp_trig_in;
   logic                     rsp_busy_ff;
   logic                     rsp_done_ff, rsp_done_in;
   logic                     rsp_tmo_ff, rsp_tmo_in;
   logic [DIST_WIDTH-1:0]    rsp_dist_ff, rsp_dist_in;

   logic                     take;
   logic                     rising;
   logic                     falling;
   logic [TRIG_WIDTH-1:0]    trig_len;

   // register file
   assign reg_sel   = reg_index_type'(paddr[3:2]);
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_dist_ff <= MAX_DIST_RST;
         trig_len_ff <= TRIG_RST;
         timeout_ff  <= TIMEOUT_RST;
      end else if (csr_write) begin
         case (reg_sel)
            REG_MAX_DIST: max_dist_ff <= pwdata[DIST_WIDTH-1:0];
            REG_TRIG:     trig_len_ff <= pwdata[TRIG_WIDTH-1:0];
            REG_TIMEOUT:  timeout_ff  <= pwdata[TIMEOUT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_MAX_DIST: prdata = DATA_WIDTH'(max_dist_ff);
         REG_TRIG:     prdata = DATA_WIDTH'(trig_len_ff);
         REG_TIMEOUT:  prdata = DATA_WIDTH'(timeout_ff);
         default:      prdata = '0;
      endcase
   end

   // tick logic
   assign take      = req.valid && req.ready;
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign rising    = req.echo && !echo_prev_ff;
   assign falling   = !req.echo && echo_prev_ff;
   assign trig_len  = (trig_len_ff == '0) ? TRIG_WIDTH'(1) : trig_len_ff;

   always_comb begin
      phase_in    = phase_ff;
      trig_cnt_in = trig_cnt_ff;
      tick_cnt_in = tick_cnt_ff;
      rem_in      = rem_ff;
      cm_in       = cm_ff;
      rsp_trig_in = 1'b0;
      rsp_done_in = 1'b0;
      rsp_tmo_in  = 1'b0;
      rsp_dist_in = '0;

      if (phase_in == PH_IDLE && req.start_req) begin
         phase_in    = PH_TRIG;
         trig_cnt_in = '0;
      end

      if (phase_in == PH_TRIG) begin
         rsp_trig_in = 1'b1;
         trig_cnt_in = trig_cnt_in + TRIG_WIDTH'(1);
         if (trig_cnt_in >= trig_len) begin
            phase_in    = PH_RISE;
            tick_cnt_in = '0;
         end
      end else if (phase_in != PH_IDLE) begin
         if (phase_in == PH_RISE) begin
            if (rising) begin
               phase_in = PH_FALL;
               rem_in   = '0;
               cm_in    = '0;
            end
         end else if (falling) begin
            rsp_done_in = 1'b1;
            rsp_dist_in = (cm_ff > max_dist_ff) ? max_dist_ff : cm_ff;
            phase_in    = PH_IDLE;
         end
         if (phase_in != PH_IDLE) begin
            tick_cnt_in = tick_cnt_in + COUNTER_WIDTH'(1);
            if (rem_in == REM_WIDTH'(CM_DIVISOR - 1)) begin
               rem_in = '0;
               cm_in  = cm_in + DIST_WIDTH'(1);
            end else begin
               rem_in = rem_in + REM_WIDTH'(1);
            end
            if (tick_cnt_in >= COUNTER_WIDTH'(timeout_ff)) begin
               rsp_done_in = 1'b1;
               rsp_tmo_in  = 1'b1;
               rsp_dist_in = max_dist_ff;
               phase_in    = PH_IDLE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         trig_cnt_ff  <= '0;
         tick_cnt_ff  <= '0;
         rem_ff       <= '0;
         cm_ff        <= '0;
         echo_prev_ff <= 1'b0;
      end else if (take) begin
         phase_ff     <= phase_in;
         trig_cnt_ff  <= trig_cnt_in;
         tick_cnt_ff  <= tick_cnt_in;
         rem_ff       <= rem_in;
         cm_ff        <= cm_in;
         echo_prev_ff <= req.echo;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_trig_ff <= rsp_trig_in;
         rsp_busy_ff <= (phase_in != PH_IDLE);
         rsp_done_ff <= rsp_done_in;
         rsp_tmo_ff  <= rsp_tmo_in;
         rsp_dist_ff <= rsp_dist_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.trigger     = rsp_trig_ff;
   assign rsp.busy_res    = rsp_busy_ff;
   assign rsp.done_res    = rsp_done_ff;
   assign rsp.timed_out   = rsp_tmo_ff;
   assign rsp.distance_cm = rsp_dist_ff;

endmodule

@@ sim/tb_ultrasonic_echo_ranger_unit.sv @@
// testbench for ultrasonic_echo_ranger_unit: drives tick words with random gaps and
// stalls, predicts every result word in-line and checks each field, plus apb readback
// depends on uer_pkg, uer_req_if, uer_rsp_if and the ultrasonic_echo_ranger_unit rtl
`timescale 1ns / 1ps

module tb_ultrasonic_echo_ranger_unit;
   import uer_pkg::*;

   typedef struct packed {
      logic                  trigger;
      logic                  busy_res;
      logic                  done_res;
      logic                  timed_out;
      logic [DIST_WIDTH-1:0] distance_cm;
   } range_word_type;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [ADDR_WIDTH-1:0] paddr;
   logic [DATA_WIDTH-1:0] pwdata;
   logic [DATA_WIDTH-1:0] prdata;
   logic                  pready;

   uer_req_if req_ch ();
   uer_rsp_if rsp_ch ();

   ultrasonic_echo_ranger_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // register shadows
   logic [DIST_WIDTH-1:0]    limit_cm;
   logic [TRIG_WIDTH-1:0]    pulse_len;
   logic [TIMEOUT_WIDTH-1:0] wait_limit;

   // ranger state as predicted
   phase_type                    phase_now;
   logic [7:0]                   pulse_count;
   logic [COUNTER_WIDTH_DEF-1:0] tick_count;
   logic [COUNTER_WIDTH_DEF-1:0] rise_stamp;
   logic                         echo_last;

   range_word_type range_words_due[$];

   int unsigned error_count;
   int unsigned ticks_sent;
   int unsigned words_checked;
   int unsigned ranges_measured;
   int unsigned ranges_timed_out;
   bit          req_gaps;
   bit          rsp_gaps;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic advance_ranger(input logic start_bit, input logic echo_bit);
      range_word_type               out_word;
      logic                         rising;
      logic                         falling;
      logic [7:0]                   need;
      logic [COUNTER_WIDTH_DEF-1:0] span;
      int unsigned                  cm;
      out_word = '0;
      rising   = echo_bit && !echo_last;
      falling  = !echo_bit && echo_last;
      echo_last = echo_bit;
      if (phase_now == PH_IDLE && start_bit) begin
         phase_now   = PH_TRIG;
         pulse_count = '0;
      end
      if (phase_now == PH_TRIG) begin
         need = (pulse_len == 8'd0) ? 8'd1 : pulse_len;
         out_word.trigger = 1'b1;
         pulse_count = pulse_count + 8'd1;
         if (pulse_count >= need) begin
            phase_now  = PH_RISE;
            tick_count = '0;
         end
      end else if (phase_now == PH_RISE || phase_now == PH_FALL) begin
         if (phase_now == PH_RISE) begin
            if (rising) begin
               rise_stamp = tick_count;
               phase_now  = PH_FALL;
            end
         end else if (falling) begin
            span = tick_count - rise_stamp;
            cm   = span / CM_DIVISOR;
            if (cm > limit_cm) cm = 32'(limit_cm);
            out_word.distance_cm = DIST_WIDTH'(cm);
            out_word.done_res    = 1'b1;
            phase_now = PH_IDLE;
         end
         if (phase_now != PH_IDLE) begin
            tick_count = tick_count + COUNTER_WIDTH_DEF'(1);
            if (tick_count >= wait_limit) begin
               out_word.done_res    = 1'b1;
               out_word.timed_out   = 1'b1;
               out_word.distance_cm = limit_cm;
               phase_now = PH_IDLE;
            end
         end
      end
      out_word.busy_res = (phase_now != PH_IDLE);
      range_words_due.push_back(out_word);
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : result_check
      range_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         words_checked++;
         if (range_words_due.size() == 0) begin
            error_count++;
            $display("%0t ns: result word with none pending, expected none, got %b%b%b%b %0d",
                     $time, rsp_ch.trigger, rsp_ch.busy_res, rsp_ch.done_res,
                     rsp_ch.timed_out, rsp_ch.distance_cm);
         end else begin
            want = range_words_due.pop_front();
            if (want.done_res) begin
               if (want.timed_out) ranges_timed_out++;
               else ranges_measured++;
            end
            check_field("trigger", 32'(want.trigger), 32'(rsp_ch.trigger));
            check_field("busy_res", 32'(want.busy_res), 32'(rsp_ch.busy_res));
            check_field("done_res", 32'(want.done_res), 32'(rsp_ch.done_res));
            check_field("timed_out", 32'(want.timed_out), 32'(rsp_ch.timed_out));
            check_field("distance_cm", 32'(want.distance_cm), 32'(rsp_ch.distance_cm));
         end
      end
   end

   // result side back-pressure
   initial begin
      int unsigned gap;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = rsp_gaps ? $urandom_range(0, 8) : 0;
         if (gap != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
      end
   end

   task automatic send_tick(input logic start_bit, input logic echo_bit);
      int unsigned gap;
      gap = req_gaps ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.start_req <= start_bit;
      req_ch.echo      <= echo_bit;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      advance_ranger(start_bit, echo_bit);
      ticks_sent++;
   endtask

   // finish any measurement, then wait for every result word
   task automatic settle();
      while (phase_now != PH_IDLE) send_tick(1'b0, 1'b0);
      req_ch.valid <= 1'b0;
      while (range_words_due.size() != 0) @(posedge clock);
   endtask

   task automatic csr_read(input reg_index_type idx);
      logic [DATA_WIDTH-1:0] want;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= ADDR_WIDTH'({idx, 2'b00});
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         REG_MAX_DIST: want = DATA_WIDTH'(limit_cm);
         REG_TRIG:     want = DATA_WIDTH'(pulse_len);
         REG_TIMEOUT:  want = DATA_WIDTH'(wait_limit);
         default:      want = '0;
      endcase
      if (prdata !== want) begin
         error_count++;
         $display("%0t ns: register %s readback expected %0d, got %0d",
                  $time, idx.name(), want, prdata);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [DATA_WIDTH-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_WIDTH'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         REG_MAX_DIST: limit_cm   = value[DIST_WIDTH-1:0];
         REG_TRIG:     pulse_len  = value[TRIG_WIDTH-1:0];
         REG_TIMEOUT:  wait_limit = value[TIMEOUT_WIDTH-1:0];
         default:      ;
      endcase
      csr_read(idx);
   endtask

   // lead ticks low, hold ticks high, then one low tick
   task automatic echo_pulse(input int unsigned lead, input int unsigned hold,
                             input bit chatter);
      repeat (lead) send_tick(chatter ? 1'($urandom_range(0, 1)) : 1'b0, 1'b0);
      repeat (hold) send_tick(chatter ? 1'($urandom_range(0, 1)) : 1'b0, 1'b1);
      send_tick(1'b0, 1'b0);
   endtask

   task automatic range_once(input logic pre_echo, input int unsigned lead,
                             input int unsigned hold, input bit chatter);
      send_tick(1'b1, pre_echo);
      while (phase_now == PH_TRIG)
         send_tick(chatter ? 1'($urandom_range(0, 1)) : 1'b0, pre_echo);
      echo_pulse(lead, hold, chatter);
   endtask

   task automatic test_register_reset();
      csr_read(REG_MAX_DIST);
      csr_read(REG_TRIG);
      csr_read(REG_TIMEOUT);
   endtask

   task automatic test_basic_range();
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);
      range_once(1'b0, 3, 60, 1'b1);
      settle();
   endtask

   task automatic test_trigger_lengths();
      csr_write(REG_TRIG, 0);
      range_once(1'b0, 2, 58, 1'b0);
      settle();
      csr_write(REG_TRIG, 1);
      range_once(1'b0, 0, 59, 1'b0);
      settle();
      csr_write(REG_TRIG, 255);
      range_once(1'b0, 1, 58, 1'b1);
      settle();
      csr_write(REG_TRIG, 32'hFFFF_FF05);
      range_once(1'b0, 1, 5, 1'b0);
      settle();
   endtask

   // echo already high when the pulse ends: only a fresh low-to-high counts
   task automatic test_echo_high_at_trigger_end();
      range_once(1'b1, 0, 4, 1'b0);
      echo_pulse(2, 58, 1'b0);
      settle();
   endtask

   task automatic test_timeouts();
      csr_write(REG_TIMEOUT, 0);
      range_once(1'b0, 0, 3, 1'b0);
      settle();
      csr_write(REG_TIMEOUT, 1);
      range_once(1'b0, 0, 3, 1'b0);
      settle();
      csr_write(REG_TIMEOUT, 20);
      range_once(1'b0, 30, 5, 1'b0);
      range_once(1'b0, 5, 25, 1'b0);
      settle();
      csr_write(REG_TIMEOUT, 300);
      range_once(1'b0, 1, 59, 1'b0);
      settle();
   endtask

   task automatic test_distance_limits();
      csr_write(REG_MAX_DIST, 0);
      range_once(1'b0, 2, 58, 1'b0);
      settle();
      csr_write(REG_MAX_DIST, 1);
      range_once(1'b0, 0, 116, 1'b0);
      settle();
      csr_write(REG_MAX_DIST, 32'hFFFF_FFFF);
      range_once(1'b0, 1, 58, 1'b0);
      settle();
      csr_write(REG_TIMEOUT, 20);
      range_once(1'b0, 30, 0, 1'b0);
      settle();
      csr_write(REG_MAX_DIST, 1129);
   endtask

   // widest echo that still completes before the timeout, then a stuck-high echo
   task automatic test_longest_echo();
      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      csr_write(REG_TIMEOUT, 60);
      csr_write(REG_MAX_DIST, 2047);
      range_once(1'b0, 0, 59, 1'b0);
      range_once(1'b0, 5, 60, 1'b0);
      settle();
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
   endtask

   task automatic test_random_ranging();
      int unsigned           round_tick;
      int unsigned           round;
      int unsigned           lead;
      int unsigned           hold;
      logic [DATA_WIDTH-1:0] lim;
      logic [DATA_WIDTH-1:0] plen;
      logic [DATA_WIDTH-1:0] tmo;
      round = 0;
      while (ticks_sent < 1450) begin
         settle();
         case (round)
            0: begin lim = 2047; plen = 1; tmo = 200; end
            1: begin lim = 0; plen = 0; tmo = 90; end
            2: begin lim = 3; plen = 2; tmo = 1; end
            3: begin lim = 1129; plen = 7; tmo = 250; end
            default: begin
               lim  = $urandom_range(0, 2047);
               plen = $urandom_range(0, 16);
               tmo  = $urandom_range(0, 300);
            end
         endcase
         req_gaps = (round % 3 != 2);
         rsp_gaps = (round % 4 != 3);
         csr_write(REG_MAX_DIST, lim);
         csr_write(REG_TRIG, plen);
         csr_write(REG_TIMEOUT, tmo);
         round_tick = ticks_sent;
         while (ticks_sent - round_tick < 60 && ticks_sent < 1450) begin
            if ($urandom_range(0, 4) == 0) begin
               repeat ($urandom_range(1, 8))
                  send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
               lead = $urandom_range(0, 12);
               hold = ($urandom_range(0, 3) == 0) ? $urandom_range(58, 260)
                                                 : $urandom_range(0, 70);
               range_once($urandom_range(0, 5) == 0, lead, hold, 1'($urandom_range(0, 1)));
            end
         end
         round++;
      end
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
   endtask

   initial begin
      reset            <= 1'b1;
      psel             <= 1'b0;
      penable          <= 1'b0;
      pwrite           <= 1'b0;
      paddr            <= '0;
      pwdata           <= '0;
      req_ch.valid     <= 1'b0;
      req_ch.start_req <= 1'b0;
      req_ch.echo      <= 1'b0;
      req_gaps    = 1'b1;
      rsp_gaps    = 1'b1;
      limit_cm    = MAX_DIST_RST;
      pulse_len   = TRIG_RST;
      wait_limit  = TIMEOUT_RST;
      phase_now   = PH_IDLE;
      pulse_count = '0;
      tick_count  = '0;
      rise_stamp  = '0;
      echo_last   = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_register_reset();
      test_basic_range();
      test_trigger_lengths();
      test_echo_high_at_trigger_end();
      test_timeouts();
      test_distance_limits();
      test_longest_echo();
      test_random_ranging();

      settle();
      repeat (20) @(posedge clock);
      $display("ranger run: %0d tick words sent, %0d result words checked",
               ticks_sent, words_checked);
      $display("measurements: %0d ranged, %0d timed out", ranges_measured, ranges_timed_out);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ ultrasonic_echo_ranger_unit.f @@
sv/uer_pkg.sv
sv/uer_req_if.sv
sv/uer_rsp_if.sv
sv/ultrasonic_echo_ranger_unit.sv
sim/tb_ultrasonic_echo_ranger_unit.sv
